// ===== rtl/xcp_pkg.sv =====
// ----------------------------------------------------------------------------
// XID control vector parser package
// Shared constants, byte positions and the result record of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package xcp_pkg;

    localparam int unsigned LENGTH_BITS = 16;
    localparam logic [LENGTH_BITS-1:0] MAX_POS = '1;

    localparam int unsigned START_BITS = 17;
    localparam int unsigned WALK_BITS  = START_BITS + 1;

    localparam logic [7:0] CV_NEG_ERROR = 8'h22;
    localparam logic [3:0] FMT_NIBBLE_0 = 4'h0;
    localparam logic [3:0] FMT_NIBBLE_3 = 4'h3;

    localparam int unsigned POS_FORMAT    = 0;
    localparam int unsigned POS_NODE_0    = 2;
    localparam int unsigned POS_NODE_1    = 3;
    localparam int unsigned POS_NODE_2    = 4;
    localparam int unsigned POS_NODE_3    = 5;
    localparam int unsigned POS_VAR_FIELD = 18;
    localparam int unsigned POS_IFRAME_HI = 21;
    localparam int unsigned POS_IFRAME_LO = 22;
    localparam int unsigned POS_WINDOW    = 27;

    localparam int unsigned MIN_LEN_NODE   = 6;
    localparam int unsigned MIN_LEN_IFRAME = 22;
    localparam int unsigned MIN_LEN_WINDOW = 27;
    localparam logic [7:0]  SENSE_LEN_MIN  = 8'd3;

    localparam int unsigned CV_OFS_HI  = 2;
    localparam int unsigned CV_OFS_LO  = 3;
    localparam int unsigned CV_BIT_OFS = 4;
    localparam int unsigned CV_SENSE_0 = 5;
    localparam int unsigned CV_SENSE_1 = 6;
    localparam int unsigned CV_SENSE_2 = 7;
    localparam int unsigned CV_SENSE_3 = 8;

    typedef enum logic [1:0] {
        FMT_NULL = 2'd0,
        FMT_0    = 2'd1,
        FMT_3    = 2'd2,
        FMT_BAD  = 2'd3
    } format_t;

    // Declared from the highest bit down, so format_code sits in the lowest bits.
    typedef struct packed {
        logic        length_overflow;
        logic [31:0] sense_code;
        logic        sense_present;
        logic [7:0]  error_bit_offset;
        logic [15:0] error_byte_offset;
        logic        neg_error_found;
        logic [7:0]  window_size;
        logic [15:0] max_iframe;
        logic [31:0] node_id;
        format_t     format_code;
    } result_t;

    localparam int unsigned RESULT_BITS = $bits(result_t);
    localparam int unsigned TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== rtl/xcp_parse.sv =====
// ----------------------------------------------------------------------------
// XID message parse state
// Holds the per-message capture state and forms the result for each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module xcp_parse (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            take,
    input  wire logic [7:0]      data_byte,
    input  wire logic            last_byte,
    input  wire logic            empty_message,
    output xcp_pkg::result_t     result
);
    import xcp_pkg::*;

    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    format_t                fmt_reg, fmt_next;
    logic [31:0]            node_reg, node_next;
    logic [15:0]            iframe_reg, iframe_next;
    logic [7:0]             window_reg, window_next;
    logic [START_BITS-1:0]  nvs_reg, nvs_next;
    logic [7:0]             vtype_reg, vtype_next;
    logic [7:0]             vlen_reg, vlen_next;
    logic                   found_reg, found_next;
    logic [15:0]            offset_reg, offset_next;
    logic [7:0]             bitofs_reg, bitofs_next;
    logic [31:0]            sense_reg, sense_next;
    logic                   ovf_reg, ovf_next;

    logic [WALK_BITS-1:0]   p_wide;
    logic [WALK_BITS-1:0]   start_wide;
    logic [WALK_BITS-1:0]   vec_ofs;
    logic                   sense_on;

    always_comb begin
        pos_next    = pos_reg;
        fmt_next    = fmt_reg;
        node_next   = node_reg;
        iframe_next = iframe_reg;
        window_next = window_reg;
        nvs_next    = nvs_reg;
        vtype_next  = vtype_reg;
        vlen_next   = vlen_reg;
        found_next  = found_reg;
        offset_next = offset_reg;
        bitofs_next = bitofs_reg;
        sense_next  = sense_reg;
        ovf_next    = ovf_reg;
        p_wide      = WALK_BITS'(pos_reg);
        start_wide  = WALK_BITS'(nvs_reg);
        vec_ofs     = p_wide - start_wide;
        sense_on    = 1'b0;
        result      = '0;

        if (pos_reg != MAX_POS) begin
            pos_next = pos_reg + 1'b1;

            if (pos_reg == LENGTH_BITS'(POS_FORMAT)) begin
                if (data_byte[7:4] == FMT_NIBBLE_0) begin
                    fmt_next = FMT_0;
                end else if (data_byte[7:4] == FMT_NIBBLE_3) begin
                    fmt_next = FMT_3;
                end else begin
                    fmt_next = FMT_BAD;
                end
            end
            if (pos_reg == LENGTH_BITS'(POS_NODE_0)) begin
                node_next[31:24] = data_byte;
            end
            if (pos_reg == LENGTH_BITS'(POS_NODE_1)) begin
                node_next[23:16] = data_byte;
            end
            if (pos_reg == LENGTH_BITS'(POS_NODE_2)) begin
                node_next[15:8] = data_byte;
            end
            if (pos_reg == LENGTH_BITS'(POS_NODE_3)) begin
                node_next[7:0] = data_byte;
            end
            if (pos_reg == LENGTH_BITS'(POS_IFRAME_HI)) begin
                iframe_next[15:8] = data_byte;
            end
            if (pos_reg == LENGTH_BITS'(POS_IFRAME_LO)) begin
                iframe_next[7:0] = data_byte;
            end
            if (pos_reg == LENGTH_BITS'(POS_WINDOW)) begin
                window_next = data_byte;
            end

            // The length byte of the variable field places the first vector.
            if (pos_reg == LENGTH_BITS'(POS_VAR_FIELD)) begin
                nvs_next   = START_BITS'(POS_VAR_FIELD) + START_BITS'(data_byte);
                start_wide = WALK_BITS'(nvs_next);
            end

            if (pos_reg >= LENGTH_BITS'(POS_VAR_FIELD)) begin
                if (!found_reg) begin
                    if (p_wide == start_wide) begin
                        vtype_next = data_byte;
                    end else if (p_wide == start_wide + 1'b1) begin
                        vlen_next = data_byte;
                        if (vtype_reg == CV_NEG_ERROR) begin
                            found_next = 1'b1;
                        end else begin
                            nvs_next = START_BITS'(start_wide + WALK_BITS'(data_byte)
                                                   + WALK_BITS'(2));
                        end
                    end
                end else if (p_wide >= start_wide) begin
                    case (vec_ofs)
                        WALK_BITS'(CV_OFS_HI):  offset_next[15:8] = data_byte;
                        WALK_BITS'(CV_OFS_LO):  offset_next[7:0]  = data_byte;
                        WALK_BITS'(CV_BIT_OFS): bitofs_next       = data_byte;
                        WALK_BITS'(CV_SENSE_0): sense_next[31:24] = data_byte;
                        WALK_BITS'(CV_SENSE_1): sense_next[23:16] = data_byte;
                        WALK_BITS'(CV_SENSE_2): sense_next[15:8]  = data_byte;
                        WALK_BITS'(CV_SENSE_3): sense_next[7:0]   = data_byte;
                        default: ;
                    endcase
                end
            end
        end else begin
            ovf_next = 1'b1;
        end

        sense_on = found_next && (vlen_next > SENSE_LEN_MIN);
        result.format_code       = (pos_next == '0) ? FMT_NULL : fmt_next;
        result.node_id           = (pos_next >= LENGTH_BITS'(MIN_LEN_NODE)) ? node_next : '0;
        result.max_iframe        = (pos_next > LENGTH_BITS'(MIN_LEN_IFRAME)) ? iframe_next : '0;
        result.window_size       = (pos_next > LENGTH_BITS'(MIN_LEN_WINDOW)) ? window_next : '0;
        result.neg_error_found   = found_next;
        result.error_byte_offset = found_next ? offset_next : '0;
        result.error_bit_offset  = found_next ? bitofs_next : '0;
        result.sense_present     = sense_on;
        result.sense_code        = sense_on ? sense_next : '0;
        result.length_overflow   = ovf_next;

        if (empty_message) begin
            result = '0;
        end

        // Every message starts from a clean state after its result.
        if (empty_message || last_byte) begin
            pos_next    = '0;
            fmt_next    = FMT_NULL;
            node_next   = '0;
            iframe_next = '0;
            window_next = '0;
            nvs_next    = '0;
            vtype_next  = '0;
            vlen_next   = '0;
            found_next  = 1'b0;
            offset_next = '0;
            bitofs_next = '0;
            sense_next  = '0;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            fmt_reg    <= FMT_NULL;
            node_reg   <= '0;
            iframe_reg <= '0;
            window_reg <= '0;
            nvs_reg    <= '0;
            vtype_reg  <= '0;
            vlen_reg   <= '0;
            found_reg  <= 1'b0;
            offset_reg <= '0;
            bitofs_reg <= '0;
            sense_reg  <= '0;
            ovf_reg    <= 1'b0;
        end else if (take) begin
            pos_reg    <= pos_next;
            fmt_reg    <= fmt_next;
            node_reg   <= node_next;
            iframe_reg <= iframe_next;
            window_reg <= window_next;
            nvs_reg    <= nvs_next;
            vtype_reg  <= vtype_next;
            vlen_reg   <= vlen_next;
            found_reg  <= found_next;
            offset_reg <= offset_next;
            bitofs_reg <= bitofs_next;
            sense_reg  <= sense_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/xid_field_and_cv22_parser.sv =====
// ----------------------------------------------------------------------------
// XID field and control vector 0x22 parser
// Streams the bytes of one XID message and reports its fields on the last byte.
// ----------------------------------------------------------------------------
// The block takes one message byte per cycle when the input is not stalled.
// A result appears in the cycle after the transfer that carries the last byte
// or an empty-message mark, and is held in the single output register until
// taken. While a result waits and the sink is not ready, the input is stalled
// for every byte; in a cycle where the sink takes the result, a new byte is
// accepted in the same cycle. Every byte goes through one pass of compare and
// capture logic between the parse state registers and the output register.
`default_nettype none

module xid_field_and_cv22_parser (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,  // data_byte
    input  wire logic                           s_tlast,  // last_byte
    input  wire logic                           s_tuser,  // empty_message
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // format_code, node_id, max_iframe, window_size, neg_error_found,
    // error_byte_offset, error_bit_offset, sense_present, sense_code,
    // length_overflow, then zero padding
    output logic [xcp_pkg::TDATA_BITS-1:0]      m_tdata
);
    import xcp_pkg::*;

    logic    take;
    result_t result;
    logic    m_tvalid_reg, m_tvalid_next;
    result_t m_data_reg, m_data_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    xcp_parse u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .take          (take),
        .data_byte     (s_tdata),
        .last_byte     (s_tlast),
        .empty_message (s_tuser),
        .result        (result)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        if (s_tready) begin
            m_tvalid_next = take && (s_tlast || s_tuser);
            m_data_next   = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_BITS'(m_data_reg);

endmodule

`default_nettype wire

// ===== rtl/xcp_checker.sv =====
// ----------------------------------------------------------------------------
// XID parser port checker
// Checks result timing and field consistency seen at the parser's ports.
// ----------------------------------------------------------------------------
`default_nettype none

module xcp_checker (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    input  wire logic                       s_tready,
    input  wire logic [7:0]                 s_tdata,
    input  wire logic                       s_tlast,
    input  wire logic                       s_tuser,
    input  wire logic                       m_tvalid,
    input  wire logic                       m_tready,
    input  wire logic [xcp_pkg::TDATA_BITS-1:0] m_tdata
);
    import xcp_pkg::*;

    result_t r;
    logic    s_xfer;

    assign r      = result_t'(m_tdata[RESULT_BITS-1:0]);
    assign s_xfer = s_tvalid && s_tready && (s_tdata == s_tdata);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An empty-message transfer gives an all-zero result in the next cycle.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_tuser |=> m_tvalid && (m_tdata == '0))
        else $error("empty message result not zero");

    // A last-byte transfer gives a result in the next cycle.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_tlast |=> m_tvalid)
        else $error("missing result after last byte");

    // A mid-message byte produces no result.
    a_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && !s_tlast && !s_tuser |=> !m_tvalid)
        else $error("result after mid-message byte");

    // Vector fields are zero unless a negotiation error vector was found.
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !r.neg_error_found |-> !r.sense_present
            && (r.error_byte_offset == '0) && (r.error_bit_offset == '0)
            && (r.sense_code == '0))
        else $error("vector fields set without a found vector");

endmodule

bind xid_field_and_cv22_parser xcp_checker u_xcp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== test/xid_field_and_cv22_parser_test.sv =====
// ----------------------------------------------------------------------------
// XID field and control vector 0x22 parser testbench
// Streams directed and random XID messages through the parser, predicts the
// fields of every message in a scoreboard and compares each result transfer
// field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module xid_field_and_cv22_parser_test;

    import xcp_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 530;

    class xid_result_scoreboard;

        result_t                predicted[$];
        int                     failures;
        int                     results_checked;
        int                     predicted_count;
        int                     vectors_seen;
        int                     overflows_seen;

        logic [LENGTH_BITS-1:0] byte_pos;
        format_t                format_held;
        logic [31:0]            node_acc;
        logic [15:0]            iframe_acc;
        logic [7:0]             window_held;
        logic [START_BITS-1:0]  vector_start;
        logic [7:0]             vector_type;
        logic [7:0]             vector_len;
        logic                   found;
        logic [15:0]            offset_acc;
        logic [7:0]             bit_offset;
        logic [31:0]            sense_acc;
        logic                   overflow;

        function new();
            failures        = 0;
            results_checked = 0;
            predicted_count = 0;
            vectors_seen    = 0;
            overflows_seen  = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            byte_pos     = '0;
            format_held  = FMT_NULL;
            node_acc     = '0;
            iframe_acc   = '0;
            window_held  = '0;
            vector_start = '0;
            vector_type  = '0;
            vector_len   = '0;
            found        = 1'b0;
            offset_acc   = '0;
            bit_offset   = '0;
            sense_acc    = '0;
            overflow     = 1'b0;
        endfunction

        function void note_transfer(logic [7:0] b, logic last, logic empty);
            int unsigned p;
            int unsigned s;
            int unsigned count;
            logic        sense;
            result_t     r;
            r = '0;
            if (empty) begin
                predicted.push_back(r);
                predicted_count++;
                clear_parse();
                return;
            end
            if (byte_pos < MAX_POS) begin
                p = 32'(byte_pos);
                if (p == POS_FORMAT) begin
                    if (b[7:4] == FMT_NIBBLE_0) begin
                        format_held = FMT_0;
                    end else if (b[7:4] == FMT_NIBBLE_3) begin
                        format_held = FMT_3;
                    end else begin
                        format_held = FMT_BAD;
                    end
                end
                if (p >= POS_NODE_0 && p <= POS_NODE_3)
                    node_acc |= 32'(b) << (8 * (POS_NODE_3 - p));
                if (p == POS_IFRAME_HI)
                    iframe_acc[15:8] = b;
                if (p == POS_IFRAME_LO)
                    iframe_acc[7:0] = b;
                if (p == POS_WINDOW)
                    window_held = b;
                if (p == POS_VAR_FIELD)
                    vector_start = START_BITS'(POS_VAR_FIELD + 32'(b));
                if (p >= POS_VAR_FIELD) begin
                    s = 32'(vector_start);
                    if (!found) begin
                        if (p == s) begin
                            vector_type = b;
                        end else if (p == s + 1) begin
                            vector_len = b;
                            if (vector_type == CV_NEG_ERROR) begin
                                found = 1'b1;
                            end else begin
                                vector_start = START_BITS'(s + 32'(b) + 2);
                            end
                        end
                    end else begin
                        if (p == s + CV_OFS_HI) begin
                            offset_acc[15:8] = b;
                        end else if (p == s + CV_OFS_LO) begin
                            offset_acc[7:0] = b;
                        end else if (p == s + CV_BIT_OFS) begin
                            bit_offset = b;
                        end else if (p >= s + CV_SENSE_0 && p <= s + CV_SENSE_3) begin
                            sense_acc |= 32'(b) << (8 * (s + CV_SENSE_3 - p));
                        end
                    end
                end
                byte_pos++;
            end else begin
                overflow = 1'b1;
            end
            if (!last)
                return;
            count               = 32'(byte_pos);
            sense               = found && (vector_len > SENSE_LEN_MIN);
            r.format_code       = (count == 0) ? FMT_NULL : format_held;
            r.node_id           = (count >= MIN_LEN_NODE) ? node_acc : '0;
            r.max_iframe        = (count > MIN_LEN_IFRAME) ? iframe_acc : '0;
            r.window_size       = (count > MIN_LEN_WINDOW) ? window_held : '0;
            r.neg_error_found   = found;
            r.error_byte_offset = found ? offset_acc : '0;
            r.error_bit_offset  = found ? bit_offset : '0;
            r.sense_present     = sense;
            r.sense_code        = sense ? sense_acc : '0;
            r.length_overflow   = overflow;
            predicted.push_back(r);
            predicted_count++;
            clear_parse();
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                failures++;
                if (failures <= 10)
                    $display("Mismatch in %s: expected %h, got %h.", field, want, got);
            end
        endfunction

        function void check_result(logic [TDATA_BITS-1:0] data);
            result_t want;
            result_t got;
            got = data[RESULT_BITS-1:0];
            if (predicted.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("Result transfer with no prediction waiting: %h.", data);
                return;
            end
            want = predicted.pop_front();
            results_checked++;
            if (want.neg_error_found)
                vectors_seen++;
            if (want.length_overflow)
                overflows_seen++;
            compare_field("format_code", 32'(want.format_code), 32'(got.format_code));
            compare_field("node_id", want.node_id, got.node_id);
            compare_field("max_iframe", 32'(want.max_iframe), 32'(got.max_iframe));
            compare_field("window_size", 32'(want.window_size), 32'(got.window_size));
            compare_field("neg_error_found", 32'(want.neg_error_found),
                          32'(got.neg_error_found));
            compare_field("error_byte_offset", 32'(want.error_byte_offset),
                          32'(got.error_byte_offset));
            compare_field("error_bit_offset", 32'(want.error_bit_offset),
                          32'(got.error_bit_offset));
            compare_field("sense_present", 32'(want.sense_present),
                          32'(got.sense_present));
            compare_field("sense_code", want.sense_code, got.sense_code);
            compare_field("length_overflow", 32'(want.length_overflow),
                          32'(got.length_overflow));
        endfunction

    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // data_byte
    logic                  s_tlast;   // last_byte
    logic                  s_tuser;   // empty_message
    logic                  m_tvalid;
    logic                  m_tready;
    // format_code, node_id, max_iframe, window_size, neg_error_found,
    // error_byte_offset, error_bit_offset, sense_present, sense_code,
    // length_overflow, then zero padding
    logic [TDATA_BITS-1:0] m_tdata;

    xid_result_scoreboard  sb;
    logic [7:0]            frame[$];
    bit                    quiet;
    int                    items_sent;
    int                    messages_sent;
    int                    cycle_count = 0;

    xid_field_and_cv22_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
    end

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 17);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid)
                @(posedge aclk);
        end
    end

    task automatic send_item(logic [7:0] b, logic last, logic empty);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        s_tuser  <= empty;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_transfer(b, last, empty);
        items_sent++;
        if (last || empty)
            messages_sent++;
    endtask

    task automatic send_frame(bit with_last);
        for (int i = 0; i < frame.size(); i++)
            send_item(frame[i], with_last && (i == frame.size() - 1), 1'b0);
    endtask

    task automatic push_random(int n);
        repeat (n) frame.push_back(8'($urandom));
    endtask

    task automatic push_fill(int n, logic [7:0] value);
        repeat (n) frame.push_back(value);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (sb.predicted.size() != 0)
            @(posedge aclk);
    endtask

    // Header, variable field, a chain of other vectors and usually a vector
    // 0x22, sometimes cut short anywhere.
    task automatic build_wellformed();
        int         var_len;
        int         vec_len;
        int         cut;
        logic [7:0] vec_type;
        frame.delete();
        case ($urandom_range(0, 3))
            0: frame.push_back({FMT_NIBBLE_0, 4'($urandom)});
            1: frame.push_back({FMT_NIBBLE_3, 4'($urandom)});
            default: frame.push_back(8'($urandom));
        endcase
        push_random(POS_VAR_FIELD - 1);
        var_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        frame.push_back(8'(var_len));
        if (var_len > 1)
            push_random(var_len - 1);
        if (var_len == 0) begin
            vec_len = $urandom_range(0, 4);
            frame.push_back(8'(vec_len));
            push_random(vec_len);
        end
        repeat ($urandom_range(0, 3)) begin
            vec_type = 8'($urandom);
            if (vec_type == CV_NEG_ERROR)
                vec_type = vec_type ^ 8'h01;
            vec_len = $urandom_range(0, 6);
            frame.push_back(vec_type);
            frame.push_back(8'(vec_len));
            push_random(vec_len);
        end
        if ($urandom_range(0, 3) != 0) begin
            vec_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 10);
            frame.push_back(CV_NEG_ERROR);
            frame.push_back(8'(vec_len));
            push_random((vec_len > 12) ? 12 : vec_len);
        end
        push_random($urandom_range(0, 6));
        if ($urandom_range(0, 4) == 0) begin
            cut   = $urandom_range(1, frame.size());
            frame = frame[0:cut-1];
        end
    endtask

    initial begin
        int pick;
        int start_items;
        sb            = new();
        quiet         = 1'b0;
        items_sent    = 0;
        messages_sent = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        s_tuser  <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty messages, alone and together with the last mark.
        send_item(8'($urandom), 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);

        // Short messages below the variable field, the last one just long enough for the node id.
        frame = {8'h05};
        send_frame(1'b1);
        frame = {8'h3A};
        push_random(4);
        send_frame(1'b1);
        frame = {8'h00, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78};
        send_frame(1'b1);

        // All ones and all zeros: bad format with the widest fields, then a
        // walk over zero-length vectors starting at the variable field byte.
        frame.delete();
        push_fill(40, 8'hFF);
        send_frame(1'b1);
        frame.delete();
        push_fill(30, 8'h00);
        send_frame(1'b1);

        // Empty variable field, one other vector, then a full vector 0x22.
        frame = {8'h30};
        push_random(POS_VAR_FIELD - 1);
        frame.push_back(8'h00);
        frame.push_back(8'h03);
        push_random(3);
        frame.push_back(CV_NEG_ERROR);
        frame.push_back(8'h08);
        push_fill(8, 8'hFF);
        send_frame(1'b1);

        // Vector 0x22 without sense data, followed by more bytes.
        frame = {8'h0C};
        push_random(POS_VAR_FIELD - 1);
        frame.push_back(8'h05);
        push_random(4);
        frame.push_back(CV_NEG_ERROR);
        frame.push_back(SENSE_LEN_MIN);
        push_random(8);
        send_frame(1'b1);

        // Truncated vector 0x22, and one whose length byte never arrives.
        frame = {8'h31};
        push_random(POS_VAR_FIELD - 1);
        frame.push_back(8'h01);
        frame.push_back(CV_NEG_ERROR);
        frame.push_back(8'h04);
        frame.push_back(8'hAB);
        send_frame(1'b1);
        frame = {8'h01};
        push_random(POS_VAR_FIELD - 1);
        frame.push_back(8'h01);
        frame.push_back(CV_NEG_ERROR);
        send_frame(1'b1);

        // Empty message in the middle of a message.
        frame.delete();
        push_random(20);
        send_frame(1'b0);
        send_item(8'($urandom), 1'($urandom), 1'b1);

        // Lengths around the thresholds of the I-frame and window fields.
        frame.delete();
        push_random(MIN_LEN_IFRAME);
        send_frame(1'b1);
        frame.delete();
        push_random(MIN_LEN_IFRAME + 1);
        send_frame(1'b1);
        frame.delete();
        push_random(MIN_LEN_WINDOW);
        send_frame(1'b1);
        frame.delete();
        push_random(MIN_LEN_WINDOW + 1);
        send_frame(1'b1);
        wait_results();

        // A message sent back to back with both sides always ready.
        quiet = 1'b1;
        frame = {8'h3F};
        push_random(9);
        send_frame(1'b1);
        quiet = 1'b0;
        wait_results();

        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 7) == 0);
            pick  = $urandom_range(0, 99);
            if (pick < 70) begin
                build_wellformed();
                send_frame(1'b1);
            end else if (pick < 80) begin
                frame.delete();
                push_random($urandom_range(1, 40));
                send_frame(1'b1);
            end else if (pick < 88) begin
                build_wellformed();
                send_frame(1'b0);
                send_item(8'($urandom), 1'($urandom), 1'b1);
            end else if (pick < 94) begin
                send_item(8'($urandom), 1'($urandom), 1'b1);
            end else begin
                frame.delete();
                push_random($urandom_range(1, POS_VAR_FIELD));
                send_frame(1'b1);
            end
        end
        quiet = 1'b0;

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.predicted.size() != 0) begin
            sb.failures++;
            $display("%0d predicted results never arrived.", sb.predicted.size());
        end

        $display("Sent %0d messages in %0d transfers and checked %0d results.",
                 messages_sent, items_sent, sb.results_checked);
        $display("Results with vector 0x22: %0d, with counter overflow: %0d.",
                 sb.vectors_seen, sb.overflows_seen);
        if (sb.failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches in total.", sb.failures);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
